// ===== hdl/positional_list_store_top_assert.svh =====
// Assertion macros shared by the positional list store RTL.
`ifndef POSITIONAL_LIST_STORE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_STORE_TOP_ASSERT_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define PLS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define PLS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/pls_pkg.sv =====
// Package with the constants, codes and command type of the positional list store.
package pls_pkg;

	localparam int DEPTH      = 16;
	localparam int ELEM_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int POS_W      = 5;
	localparam int CNT_W      = 5;
	localparam int ACT_W      = 2;
	localparam int ST_W       = 2;

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

	// Command broadcast to every cell of the chain in the cycle a request is taken.
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [POS_W-1:0] pos;
		logic [CNT_W-1:0] cnt;
	} pls_cmd_t;

endpackage

// ===== hdl/pls_cell.sv =====
// One storage cell of the list chain: holds an entry and shifts with its neighbors.
module pls_cell (
	input  logic                             clk,
	input  pls_pkg::pls_cmd_t                cmd,
	input  logic [pls_pkg::IDX_W-1:0]        idx,
	input  logic [pls_pkg::ELEM_WIDTH-1:0]   left,
	input  logic [pls_pkg::ELEM_WIDTH-1:0]   right,
	input  logic [pls_pkg::ELEM_WIDTH-1:0]   element,
	output logic [pls_pkg::ELEM_WIDTH-1:0]   data
);
	import pls_pkg::*;

	logic [ELEM_WIDTH-1:0] data_q;
	logic [POS_W-1:0]      my_pos;
	logic [POS_W-1:0]      my_next;

	assign my_pos  = POS_W'(idx);
	assign my_next = my_pos + POS_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (my_pos == cmd.pos) begin
				data_q <= element;
			end else if (my_pos > cmd.pos && my_pos <= cmd.cnt) begin
				data_q <= left;
			end
		end else if (cmd.rem) begin
			// Cells from the removed slot up to the next-to-last entry pull from the right.
			if (my_pos >= cmd.pos && my_next < cmd.cnt) begin
				data_q <= right;
			end
		end
	end

	assign data = data_q;

endmodule

// ===== hdl/positional_list_store_top.sv =====
// Top level of the positional list store: request decode, cell chain and result register.
// Positional list store. Holds an ordered list of up to "capacity" 32-bit elements
// (at most 16) in a chain of cells. Each request beat inserts at, removes at or reads
// at a position and returns one result beat with status, read data, length and a full
// flag. All cells shift in the same clock as the request is taken, so a new request is
// accepted every cycle unless the input is stalled; the result is registered in the
// cycle after its request and held while the output is stalled, which stalls the input.
// The user writes the capacity register through the cfg port while the block is idle;
// the block does not enforce this. A value of zero acts as one, a value above 16 as 16.
module positional_list_store_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pls_pkg::CNT_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [pls_pkg::ACT_W-1:0]       action,
	input  logic [pls_pkg::POS_W-1:0]       position,
	input  logic [pls_pkg::ELEM_WIDTH-1:0]  element,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [pls_pkg::ST_W-1:0]        status,
	output logic [pls_pkg::ELEM_WIDTH-1:0]  read_data,
	output logic [pls_pkg::CNT_W-1:0]       length,
	output logic                            full_res
);
	import pls_pkg::*;

	logic [CNT_W-1:0]      capacity_q;
	logic [CNT_W-1:0]      count_q;
	logic                  out_valid_q;
	logic [ST_W-1:0]       status_q;
	logic [ELEM_WIDTH-1:0] read_data_q;
	logic [CNT_W-1:0]      length_q;
	logic                  full_q;

	logic [CNT_W-1:0]      cap_eff;
	logic                  accept;
	logic                  ins_ok;
	logic                  rem_ok;
	logic [ST_W-1:0]       nxt_status;
	logic [ELEM_WIDTH-1:0] nxt_rdata;
	logic [CNT_W-1:0]      nxt_count;
	pls_cmd_t              cmd;
	logic [ELEM_WIDTH-1:0] cell_data [DEPTH];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CNT_W'(DEPTH);
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (capacity_q > CNT_W'(DEPTH)) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = capacity_q;
		end
	end

	// The input waits only while a finished result is held back by the output side.
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		ins_ok     = 1'b0;
		rem_ok     = 1'b0;
		nxt_status = ST_DONE;
		nxt_rdata  = '0;
		nxt_count  = count_q;
		case (action)
			ACT_INSERT: begin
				if (count_q >= cap_eff) begin
					nxt_status = ST_FULL;
				end else if (position > count_q) begin
					nxt_status = ST_RANGE;
				end else begin
					ins_ok    = 1'b1;
					nxt_count = count_q + CNT_W'(1);
				end
			end
			ACT_REMOVE: begin
				if (position >= count_q) begin
					nxt_status = ST_RANGE;
				end else begin
					rem_ok    = 1'b1;
					nxt_count = count_q - CNT_W'(1);
				end
			end
			ACT_READ: begin
				if (position >= count_q) begin
					nxt_status = ST_RANGE;
				end else begin
					// Position is below count, so its low bits address a valid cell.
					nxt_rdata = cell_data[position[IDX_W-1:0]];
				end
			end
			default: begin
				nxt_status = ST_DONE;
			end
		endcase
	end

	assign cmd.ins = accept && ins_ok;
	assign cmd.rem = accept && rem_ok;
	assign cmd.pos = position;
	assign cmd.cnt = count_q;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [ELEM_WIDTH-1:0] left_in;
		logic [ELEM_WIDTH-1:0] right_in;

		// The end cells never take from their missing neighbor, so those inputs are don't-care.
		if (g == 0) begin : g_first
			assign left_in = element;
		end else begin : g_left
			assign left_in = cell_data[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_in = cell_data[g];
		end else begin : g_right
			assign right_in = cell_data[g+1];
		end

		pls_cell u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.idx     (IDX_W'(g)),
			.left    (left_in),
			.right   (right_in),
			.element (element),
			.data    (cell_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= nxt_count;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= nxt_status;
			read_data_q <= nxt_rdata;
			length_q    <= nxt_count;
			full_q      <= (nxt_count >= cap_eff);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign read_data = read_data_q;
	assign length    = length_q;
	assign full_res  = full_q;

`include "positional_list_store_top_assert.svh"

	`PLS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "list length above store depth")
	`PLS_ASSERT_NEXT(a_insert_grows, cmd.ins, count_q == $past(count_q) + CNT_W'(1), "insert did not grow the list")
	`PLS_ASSERT_NEXT(a_accept_result, accept, out_valid_q && length_q == count_q, "accepted request left no matching result")
	`PLS_ASSERT_NOW(a_fail_no_data, out_valid_q && status_q != ST_DONE, read_data_q == '0, "failed request returned read data")

endmodule
